// File: src/fsl_pkg.sv
// ----------------------------------------------------------------------------
// fsl_pkg
// Shared types, constants and helpers of the fixed-string line filter.
// ----------------------------------------------------------------------------
package fsl_pkg;

   localparam int PATTERN_MAX = 32;
   localparam longint PEEK_BYTES = 65536;
   localparam int OFFSET_BITS = 32;
   localparam int LINE_BITS = 32;
   localparam int PATTERN_WORD_BYTES = 8;
   localparam int LEN_BITS = $clog2(PATTERN_MAX + 1);
   localparam int BYTE_IDX_BITS = $clog2(PATTERN_MAX);

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 64;

   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_0 = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_1 = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_2 = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_3 = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CASE_INSENSITIVE = 3'd5;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'd32;

   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
   localparam logic [OFFSET_BITS-1:0] PEEK_LIMIT = OFFSET_BITS'(PEEK_BYTES);

   typedef struct packed {
      logic [PATTERN_MAX-1:0][7:0] pattern;   // folded pattern bytes
      logic [PATTERN_MAX-1:0]      active;    // bytes in use
      logic [PATTERN_MAX-1:0]      hit_sel;   // last byte in use, one-hot
      logic                        match_all; // empty pattern
      logic                        case_fold;
   } cfg_type;

   typedef struct packed {
      logic [PATTERN_MAX-1:0] mask;
      logic                   is_newline;
      logic                   is_nul;
      logic                   last;
   } cmd_type;

   typedef struct packed {
      logic [LINE_BITS-1:0] line_start;
      logic [LINE_BITS-1:0] line_length;
      logic                 line_matched;
      logic                 end_of_file;
      logic                 binary_file;
   } rsp_type;

   function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic fold_en);
      logic upper;
      upper = (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
      return (fold_en && upper) ? c + CASE_OFFSET : c;
   endfunction

   function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
      return (v == OFFSET_MAX) ? v : v + OFFSET_BITS'(1);
   endfunction

endpackage

// File: src/fsl_csr.sv
// ----------------------------------------------------------------------------
// fsl_csr
// Pattern, length and case registers, and the settings derived from them.
// ----------------------------------------------------------------------------
module fsl_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                valid,
   output logic                                ready,
   input  logic [fsl_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [fsl_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output fsl_pkg::cfg_type                    cfg
);

   logic [fsl_pkg::PATTERN_MAX-1:0][7:0] pattern_ff, pattern_in;
   logic [fsl_pkg::LEN_BITS-1:0]         length_ff, length_in;
   logic                                 case_ff, case_in;
   logic [fsl_pkg::LEN_BITS-1:0]         len_clamped;

   assign ready = 1'b1;

   always_comb begin
      pattern_in = pattern_ff;
      length_in  = length_ff;
      case_in    = case_ff;
      if (valid) begin
         unique case (csr_index) inside
            fsl_pkg::REG_PATTERN_0, fsl_pkg::REG_PATTERN_1,
            fsl_pkg::REG_PATTERN_2, fsl_pkg::REG_PATTERN_3: begin
               for (int b = 0; b < fsl_pkg::PATTERN_WORD_BYTES; b++) begin
                  pattern_in[{csr_index[1:0], 3'(b)}] = csr_data[8*b +: 8];
               end
            end
            fsl_pkg::REG_PATTERN_LENGTH: begin
               length_in = csr_data[fsl_pkg::LEN_BITS-1:0];
            end
            fsl_pkg::REG_CASE_INSENSITIVE: begin
               case_in = csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= '0;
         case_ff    <= 1'b0;
      end else begin
         pattern_ff <= pattern_in;
         length_ff  <= length_in;
         case_ff    <= case_in;
      end
   end

   // A length beyond the pattern store acts as the full store.
   assign len_clamped = (length_ff > fsl_pkg::LEN_BITS'(fsl_pkg::PATTERN_MAX))
                        ? fsl_pkg::LEN_BITS'(fsl_pkg::PATTERN_MAX) : length_ff;

   always_comb begin
      cfg.case_fold = case_ff;
      cfg.match_all = (len_clamped == '0);
      for (int j = 0; j < fsl_pkg::PATTERN_MAX; j++) begin
         cfg.pattern[j] = fsl_pkg::fold_byte(pattern_ff[j], case_ff);
         cfg.active[j]  = fsl_pkg::LEN_BITS'(j) < len_clamped;
         cfg.hit_sel[j] = fsl_pkg::LEN_BITS'(j + 1) == len_clamped;
      end
   end

endmodule

// File: src/fsl_front.sv
// ----------------------------------------------------------------------------
// fsl_front
// Accepts file bytes, compares each against every pattern byte and queues
// the resulting match mask and byte class for the back end.
// ----------------------------------------------------------------------------
module fsl_front (
   input  logic             clock,
   input  logic             reset,
   input  fsl_pkg::cfg_type cfg,
   input  logic             push,
   output logic             full,
   input  logic [7:0]       req_data_byte,
   input  logic             req_last_byte,
   output logic             cmd_valid,
   output fsl_pkg::cmd_type cmd,
   input  logic             cmd_pop
);

   localparam int DEPTH = 4;
   localparam int PTR_BITS = $clog2(DEPTH);

   fsl_pkg::cmd_type            queue_ff [DEPTH];
   fsl_pkg::cmd_type            cmd_new;
   logic [PTR_BITS-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]           count_ff, count_in;
   logic [7:0]                  folded;
   logic                        do_push;

   assign full    = (count_ff == (PTR_BITS+1)'(DEPTH));
   assign do_push = push && !full;

   always_comb begin
      folded = fsl_pkg::fold_byte(req_data_byte, cfg.case_fold);
      for (int j = 0; j < fsl_pkg::PATTERN_MAX; j++) begin
         cmd_new.mask[j] = cfg.active[j] && (cfg.pattern[j] == folded);
      end
      cmd_new.is_newline = (req_data_byte == fsl_pkg::CHAR_NEWLINE);
      cmd_new.is_nul     = (req_data_byte == fsl_pkg::CHAR_NUL);
      cmd_new.last       = req_last_byte;
   end

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + (PTR_BITS+1)'(do_push) - (PTR_BITS+1)'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];

endmodule

// File: src/fsl_back.sv
// ----------------------------------------------------------------------------
// fsl_back
// Shift-and matcher and line bookkeeping; builds line reports and holds them
// in a small result queue until they are taken.
// ----------------------------------------------------------------------------
module fsl_back (
   input  logic                          clock,
   input  logic                          reset,
   input  fsl_pkg::cfg_type              cfg,
   input  logic                          cmd_valid,
   input  fsl_pkg::cmd_type              cmd,
   output logic                          cmd_pop,
   output logic                          empty,
   input  logic                          pop,
   output fsl_pkg::rsp_type              rsp
);

   localparam int DEPTH = 2;
   localparam int PTR_BITS = $clog2(DEPTH);

   logic [fsl_pkg::PATTERN_MAX-1:0] mv_ff, mv_in, mv_next;
   logic [fsl_pkg::OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [fsl_pkg::OFFSET_BITS-1:0] start_ff, start_in;
   logic                            hit_ff, hit_in, hit_next;
   logic                            binary_ff, binary_in, binary_next;
   logic [fsl_pkg::OFFSET_BITS-1:0] diff, len;
   logic                            start_ok;
   logic                            report, emit, do_pop;
   fsl_pkg::rsp_type                rsp_new;

   fsl_pkg::rsp_type                queue_ff [DEPTH];
   logic [PTR_BITS-1:0]             wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]             rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]               count_ff, count_in;
   logic                            rsp_full;

   assign empty    = (count_ff == '0);
   assign do_pop   = pop && !empty;
   assign rsp_full = (count_ff == (PTR_BITS+1)'(DEPTH));
   assign cmd_pop  = cmd_valid && (!rsp_full || do_pop);

   always_comb begin
      binary_next = binary_ff ||
                    (cmd.is_nul && (offset_ff < fsl_pkg::PEEK_LIMIT));
      mv_next     = {mv_ff[fsl_pkg::PATTERN_MAX-2:0], 1'b1} & cmd.mask;
      start_ok    = (offset_ff >= start_ff);
      diff        = offset_ff - start_ff;
      if (cmd.is_newline) begin
         hit_next = hit_ff;
         len      = start_ok ? diff : '0;
         report   = 1'b1;
      end else begin
         hit_next = hit_ff || ((mv_next & cfg.hit_sel) != '0);
         len      = start_ok ? fsl_pkg::sat_inc(diff) : '0;
         report   = cmd.last;
      end

      // Once the file is marked binary only its final byte gives a report.
      if (binary_next) begin
         emit    = cmd.last;
         rsp_new = '{line_start: '0, line_length: '0, line_matched: 1'b0,
                     end_of_file: 1'b1, binary_file: 1'b1};
      end else begin
         emit                 = report;
         rsp_new.line_start   = start_ff[fsl_pkg::LINE_BITS-1:0];
         rsp_new.line_length  = len[fsl_pkg::LINE_BITS-1:0];
         rsp_new.line_matched = hit_next || cfg.match_all;
         rsp_new.end_of_file  = cmd.last;
         rsp_new.binary_file  = 1'b0;
      end

      mv_in     = mv_ff;
      hit_in    = hit_ff;
      start_in  = start_ff;
      offset_in = offset_ff;
      binary_in = binary_ff;
      if (cmd_pop) begin
         binary_in = binary_next;
         offset_in = fsl_pkg::sat_inc(offset_ff);
         if (cmd.is_newline) begin
            mv_in    = '0;
            hit_in   = 1'b0;
            start_in = fsl_pkg::sat_inc(offset_ff);
         end else begin
            mv_in  = mv_next;
            hit_in = hit_next;
         end
         if (cmd.last) begin
            mv_in     = '0;
            hit_in    = 1'b0;
            start_in  = '0;
            offset_in = '0;
            binary_in = 1'b0;
         end
      end
   end

   always_comb begin
      wr_ptr_in = (cmd_pop && emit) ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + (PTR_BITS+1)'(cmd_pop && emit) - (PTR_BITS+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff     <= '0;
         hit_ff    <= 1'b0;
         start_ff  <= '0;
         offset_ff <= '0;
         binary_ff <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         mv_ff     <= mv_in;
         hit_ff    <= hit_in;
         start_ff  <= start_in;
         offset_ff <= offset_in;
         binary_ff <= binary_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop && emit) begin
         queue_ff[wr_ptr_ff] <= rsp_new;
      end
   end

   assign rsp = queue_ff[rd_ptr_ff];

endmodule

// File: src/fixed_string_line_filter_unit.sv
// ----------------------------------------------------------------------------
// fixed_string_line_filter_unit
// A request accepted into the four-entry front queue passes to the back end,
// and any report it gives is registered in the result queue, then popped.
// Throughput: one byte per cycle while the result queue is not full; the
// shift-and update in the back end is a single step per byte.
// Reset clears all file state, the queues and the configuration registers.
// ----------------------------------------------------------------------------
module fixed_string_line_filter_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_last_byte,
   output logic                                empty,
   input  logic                                pop,
   output logic [fsl_pkg::LINE_BITS-1:0]       rsp_line_start,
   output logic [fsl_pkg::LINE_BITS-1:0]       rsp_line_length,
   output logic                                rsp_line_matched,
   output logic                                rsp_end_of_file,
   output logic                                rsp_binary_file,
   input  logic                                valid,
   output logic                                ready,
   input  logic [fsl_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [fsl_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   fsl_pkg::cfg_type cfg;
   fsl_pkg::cmd_type cmd;
   fsl_pkg::rsp_type rsp;
   logic             cmd_valid;
   logic             cmd_pop;

   fsl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .valid     (valid),
      .ready     (ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   fsl_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .push          (push),
      .full          (full),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   fsl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp       (rsp)
   );

   assign rsp_line_start   = rsp.line_start;
   assign rsp_line_length  = rsp.line_length;
   assign rsp_line_matched = rsp.line_matched;
   assign rsp_end_of_file  = rsp.end_of_file;
   assign rsp_binary_file  = rsp.binary_file;

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed-string line filter. Files are streamed in
// byte by byte: a short directed set first, then random files built mostly
// from lines that carry the pattern or parts of it, plus noise and binary
// files. A line predictor inside the bench works out every report, and each
// popped report is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Line predictor: keeps its own copy of the registers and the file state.
   class line_report_predictor;
      logic [63:0]      pat_word [4];
      logic [5:0]       pat_len_reg;
      logic             fold_en;
      logic [31:0]      hit_vec;
      logic [31:0]      next_ofs;
      logic [31:0]      line_begin;
      logic             line_hit;
      logic             bin_seen;
      fsl_pkg::rsp_type pending_reports [$];
      int               errors;

      function new();
         for (int w = 0; w < 4; w++) pat_word[w] = '0;
         pat_len_reg = '0;
         fold_en = 1'b0;
         errors = 0;
         clear_file();
      endfunction

      function void clear_file();
         hit_vec = '0;
         next_ofs = '0;
         line_begin = '0;
         line_hit = 1'b0;
         bin_seen = 1'b0;
      endfunction

      function void add_report(fsl_pkg::rsp_type r);
         pending_reports.insert(pending_reports.size(), r);
      endfunction

      function void set_register(logic [fsl_pkg::CSR_INDEX_BITS-1:0] idx, logic [63:0] data);
         case (idx)
            fsl_pkg::REG_PATTERN_0: pat_word[0] = data;
            fsl_pkg::REG_PATTERN_1: pat_word[1] = data;
            fsl_pkg::REG_PATTERN_2: pat_word[2] = data;
            fsl_pkg::REG_PATTERN_3: pat_word[3] = data;
            fsl_pkg::REG_PATTERN_LENGTH: pat_len_reg = data[5:0];
            fsl_pkg::REG_CASE_INSENSITIVE: fold_en = data[0];
            default: ;
         endcase
      endfunction

      function logic [7:0] to_lower(logic [7:0] c);
         if (fold_en && c >= fsl_pkg::CHAR_UPPER_A && c <= fsl_pkg::CHAR_UPPER_Z)
            return c | 8'h20;
         return c;
      endfunction

      function logic [31:0] bump(logic [31:0] v);
         return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
      endfunction

      function void note_byte(logic [7:0] c, logic last);
         logic [31:0]      pos;
         logic [31:0]      len;
         logic [31:0]      mask;
         logic             report;
         int               m;
         fsl_pkg::rsp_type r;
         pos = next_ofs;
         len = '0;
         report = 1'b0;
         m = (pat_len_reg > 6'd32) ? 32 : int'(pat_len_reg);
         if (c == fsl_pkg::CHAR_NUL && pos < fsl_pkg::PEEK_BYTES) bin_seen = 1'b1;
         if (c == fsl_pkg::CHAR_NEWLINE) begin
            len = (pos >= line_begin) ? pos - line_begin : 32'd0;
            report = 1'b1;
         end else begin
            mask = '0;
            for (int j = 0; j < m; j++)
               if (to_lower(pat_word[j / 8][(j % 8) * 8 +: 8]) == to_lower(c)) mask[j] = 1'b1;
            hit_vec = ((hit_vec << 1) | 32'd1) & mask;
            if (m > 0 && hit_vec[m - 1]) line_hit = 1'b1;
            if (last) begin
               len = (pos >= line_begin) ? bump(pos - line_begin) : 32'd0;
               report = 1'b1;
            end
         end
         // Once the file is known to be binary only the closing report is given.
         if (bin_seen) begin
            if (last) begin
               r = '0;
               r.end_of_file = 1'b1;
               r.binary_file = 1'b1;
               add_report(r);
            end
         end else if (report) begin
            r.line_start = line_begin;
            r.line_length = len;
            r.line_matched = line_hit || (m == 0);
            r.end_of_file = last;
            r.binary_file = 1'b0;
            add_report(r);
         end
         if (c == fsl_pkg::CHAR_NEWLINE) begin
            line_begin = bump(pos);
            hit_vec = '0;
            line_hit = 1'b0;
         end
         next_ofs = bump(pos);
         if (last) clear_file();
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("%0t ns: mismatch: %s", $time, what);
      endtask

      task check_report(fsl_pkg::rsp_type got);
         fsl_pkg::rsp_type want;
         if (pending_reports.size() == 0) begin
            report_mismatch($sformatf("report with none pending: start %0d length %0d",
                                      got.line_start, got.line_length));
            return;
         end
         want = pending_reports.pop_front();
         if (got.line_start !== want.line_start)
            report_mismatch($sformatf("line_start %0d, predicted %0d",
                                      got.line_start, want.line_start));
         if (got.line_length !== want.line_length)
            report_mismatch($sformatf("line_length %0d, predicted %0d (start %0d)",
                                      got.line_length, want.line_length, want.line_start));
         if (got.line_matched !== want.line_matched)
            report_mismatch($sformatf("line_matched %b, predicted %b (start %0d)",
                                      got.line_matched, want.line_matched, want.line_start));
         if (got.end_of_file !== want.end_of_file)
            report_mismatch($sformatf("end_of_file %b, predicted %b (start %0d)",
                                      got.end_of_file, want.end_of_file, want.line_start));
         if (got.binary_file !== want.binary_file)
            report_mismatch($sformatf("binary_file %b, predicted %b",
                                      got.binary_file, want.binary_file));
      endtask

      function int pending();
         return pending_reports.size();
      endfunction
   endclass

   logic                               clock;
   logic                               reset = 1'b1;
   logic                               push = 1'b0;
   logic                               full;
   logic [7:0]                         req_data_byte = '0;
   logic                               req_last_byte = 1'b0;
   logic                               empty;
   logic                               pop = 1'b0;
   logic [fsl_pkg::LINE_BITS-1:0]      rsp_line_start;
   logic [fsl_pkg::LINE_BITS-1:0]      rsp_line_length;
   logic                               rsp_line_matched;
   logic                               rsp_end_of_file;
   logic                               rsp_binary_file;
   logic                               valid = 1'b0;
   logic                               ready;
   logic [fsl_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [fsl_pkg::CSR_DATA_BITS-1:0]  csr_data = '0;

   line_report_predictor lines;
   fsl_pkg::rsp_type     seen_rsp;
   logic [7:0]           file_q [$];
   logic [7:0]           pat_bytes [32];
   int                   pat_used;
   int                   send_idle_pct = 0;
   int                   recv_idle_pct = 0;
   int                   hold_request = 0;
   int                   hold_left = 0;
   int                   items_sent = 0;

   fixed_string_line_filter_unit DUT (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .empty(empty),
      .pop(pop),
      .rsp_line_start(rsp_line_start),
      .rsp_line_length(rsp_line_length),
      .rsp_line_matched(rsp_line_matched),
      .rsp_end_of_file(rsp_end_of_file),
      .rsp_binary_file(rsp_binary_file),
      .valid(valid),
      .ready(ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // Receiver: a requested hold-off is counted down here, one cycle at a time.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            pop = 1'b0;
            hold_left--;
         end else begin
            pop = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         seen_rsp.line_start = rsp_line_start;
         seen_rsp.line_length = rsp_line_length;
         seen_rsp.line_matched = rsp_line_matched;
         seen_rsp.end_of_file = rsp_end_of_file;
         seen_rsp.binary_file = rsp_binary_file;
         lines.check_report(seen_rsp);
      end
   end

   function automatic void add_byte(logic [7:0] b);
      file_q.insert(file_q.size(), b);
   endfunction

   function automatic logic [63:0] pattern_word(int w);
      logic [63:0] word;
      for (int b = 0; b < 8; b++) word[b * 8 +: 8] = pat_bytes[w * 8 + b];
      return word;
   endfunction

   // All driving tasks start and return just after a falling edge.
   task automatic write_reg(logic [fsl_pkg::CSR_INDEX_BITS-1:0] idx, logic [63:0] data);
      valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      @(posedge clock);
      while (!ready) @(posedge clock);
      lines.set_register(idx, data);
      @(negedge clock);
      valid = 1'b0;
   endtask

   task automatic program_pattern(int len_val, logic fold);
      write_reg(fsl_pkg::REG_PATTERN_0, pattern_word(0));
      write_reg(fsl_pkg::REG_PATTERN_1, pattern_word(1));
      write_reg(fsl_pkg::REG_PATTERN_2, pattern_word(2));
      write_reg(fsl_pkg::REG_PATTERN_3, pattern_word(3));
      // Unused upper bits carry noise; only the low bits may take effect.
      write_reg(fsl_pkg::REG_PATTERN_LENGTH, {$urandom, 26'($urandom), len_val[5:0]});
      write_reg(fsl_pkg::REG_CASE_INSENSITIVE, {$urandom, $urandom} & ~64'd1 | 64'(fold));
      pat_used = (len_val > 32) ? 32 : len_val;
   endtask

   task automatic send_byte(logic [7:0] b, logic l);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      push = 1'b1;
      req_data_byte = b;
      req_last_byte = l;
      @(posedge clock);
      while (full) @(posedge clock);
      lines.note_byte(b, l);
      @(negedge clock);
      push = 1'b0;
   endtask

   task automatic send_file();
      for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
      items_sent += file_q.size();
      file_q.delete();
   endtask

   // Waits until every predicted report has been popped or the wait times out,
   // then lets the pipeline drain before any register is touched.
   task automatic wait_idle();
      int n;
      n = 0;
      while (lines.pending() != 0 && n < 5000) begin
         @(negedge clock);
         n++;
      end
      repeat (8) @(negedge clock);
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   function automatic logic [7:0] flip_case(logic [7:0] c);
      logic [7:0] low;
      low = c | 8'h20;
      if (low >= "a" && low <= "z" && $urandom_range(1)) return c ^ 8'h20;
      return c;
   endfunction

   task automatic random_config();
      int r;
      int len_val;
      int mode;
      r = $urandom_range(99);
      if (r < 8) len_val = 0;
      else if (r < 16) len_val = 32;
      else if (r < 22) len_val = $urandom_range(33, 63);
      else if (r < 30) len_val = $urandom_range(7, 31);
      else len_val = $urandom_range(1, 6);
      mode = $urandom_range(99);
      for (int j = 0; j < 32; j++) begin
         if (j < len_val && mode < 80) pat_bytes[j] = flip_case(8'h61 + 8'($urandom_range(3)));
         else pat_bytes[j] = 8'($urandom_range(255));
      end
      program_pattern(len_val, $urandom_range(1));
   endtask

   task automatic add_line(logic with_newline);
      int n;
      int k;
      int cut;
      n = ($urandom_range(9) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 12);
      k = 0;
      while (k < n) begin
         if (pat_used > 0 && $urandom_range(3) == 0) begin
            // Whole pattern or a prefix of it, to exercise partial matches.
            cut = ($urandom_range(2) == 0) ? $urandom_range(1, pat_used) : pat_used;
            for (int i = 0; i < cut; i++) add_byte(flip_case(pat_bytes[i]));
            k += cut;
         end else begin
            if (pat_used > 0 && $urandom_range(1))
               add_byte(flip_case(pat_bytes[$urandom_range(pat_used - 1)]));
            else
               add_byte(flip_case(8'h61 + 8'($urandom_range(3))));
            k++;
         end
      end
      if (with_newline) add_byte(fsl_pkg::CHAR_NEWLINE);
   endtask

   task automatic random_file();
      int r;
      int nlines;
      r = $urandom_range(99);
      if (r < 75) begin
         nlines = $urandom_range(1, 5);
         for (int i = 0; i < nlines; i++) add_line(i < nlines - 1 || $urandom_range(1));
      end else if (r < 90) begin
         repeat ($urandom_range(1, 24)) add_byte(8'($urandom_range(255)));
      end else begin
         nlines = $urandom_range(1, 3);
         for (int i = 0; i < nlines; i++) add_line($urandom_range(1));
         if (file_q.size() == 0) add_byte(flip_case(8'h61 + 8'($urandom_range(3))));
         file_q[$urandom_range(file_q.size() - 1)] = fsl_pkg::CHAR_NUL;
      end
      if (file_q.size() == 0) add_byte(8'($urandom_range(255)));
      send_file();
   endtask

   // Many short lines while the receiver holds off, so the block backs up.
   task automatic pressure_burst();
      hold_request = 300;
      repeat (40) begin
         add_text("ab");
         add_byte(fsl_pkg::CHAR_NEWLINE);
      end
      add_byte("c");
      send_file();
   endtask

   initial begin
      int start_count;
      int files_left;
      logic pressure_done;
      lines = new();
      pressure_done = 1'b0;
      files_left = 0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 32;
      recv_idle_pct = 52;

      // Exact-case pattern, a newline as the final byte, and a binary file.
      for (int j = 0; j < 32; j++) pat_bytes[j] = 8'h00;
      pat_bytes[0] = "a";
      pat_bytes[1] = "b";
      program_pattern(2, 1'b0);
      add_text("xab");
      add_byte(fsl_pkg::CHAR_NEWLINE);
      add_text("Q");
      send_file();
      add_byte(fsl_pkg::CHAR_NEWLINE);
      send_file();
      add_byte(8'hFF);
      add_byte(fsl_pkg::CHAR_NEWLINE);
      add_byte(fsl_pkg::CHAR_NUL);
      add_byte("a");
      add_byte(fsl_pkg::CHAR_NEWLINE);
      add_byte("b");
      send_file();

      // Case folding applies to both the text and the pattern.
      wait_idle();
      pat_bytes[0] = "A";
      pat_bytes[1] = "B";
      program_pattern(2, 1'b1);
      add_text("aB");
      add_byte(fsl_pkg::CHAR_NEWLINE);
      add_text("x");
      send_file();

      // An empty pattern matches every line.
      wait_idle();
      program_pattern(0, 1'b0);
      add_text("z");
      add_byte(fsl_pkg::CHAR_NEWLINE);
      add_text("y");
      send_file();

      // A pattern holding a newline can never match.
      wait_idle();
      pat_bytes[0] = "a";
      pat_bytes[1] = fsl_pkg::CHAR_NEWLINE;
      pat_bytes[2] = "b";
      program_pattern(3, 1'b0);
      add_text("a");
      add_byte(fsl_pkg::CHAR_NEWLINE);
      add_text("b");
      send_file();

      // All-ones pattern words and an over-long length that acts as the maximum.
      wait_idle();
      for (int j = 0; j < 32; j++) pat_bytes[j] = 8'hFF;
      program_pattern(63, 1'b1);
      add_byte(8'hFF);
      send_file();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 52 : 0;
         recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 32 : 0;
         start_count = items_sent;
         while (items_sent - start_count < 460) begin
            if (files_left == 0) begin
               wait_idle();
               random_config();
               files_left = $urandom_range(1, 4);
            end
            random_file();
            files_left--;
            if (phase == 0 && !pressure_done && items_sent - start_count > 200) begin
               pressure_burst();
               pressure_done = 1'b1;
            end
         end
      end

      wait_idle();
      if (lines.pending() != 0)
         lines.report_mismatch($sformatf("%0d predicted reports never arrived",
                                         lines.pending()));
      if (lines.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
